// File: rtl/palette_video_chunk_deframer_macros.svh
// Assertion macros for the chunk deframer checker.
`ifndef PALETTE_VIDEO_CHUNK_DEFRAMER_MACROS_SVH
`define PALETTE_VIDEO_CHUNK_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PVCD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pvcd: assertion failed");

// Next-cycle implication, disabled during reset
`define PVCD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pvcd: assertion failed");

`endif

// File: rtl/pvcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvcd_pkg
// Types, codes and constants shared by the chunk deframer modules.
// ----------------------------------------------------------------------------
package pvcd_pkg;

	localparam int HDR_BYTES = 32;
	localparam int HDR_IDX_W = $clog2(HDR_BYTES);
	localparam int VIDEO_W   = 29;
	localparam int LEFT_W    = 29;

	localparam logic [15:0] RST_SAMPLE_RATE = 16'd11025;
	localparam logic [15:0] RST_RATE_NUM    = 16'd15;
	localparam logic [15:0] RST_RATE_DEN    = 16'd1;

	// Result kinds
	localparam logic [2:0] KIND_DESC  = 3'd0;
	localparam logic [2:0] KIND_VIDEO = 3'd1;
	localparam logic [2:0] KIND_AUDIO = 3'd2;
	localparam logic [2:0] KIND_ERR   = 3'd3;
	localparam logic [2:0] KIND_END   = 3'd4;

	// Status codes
	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_TYPE    = 3'd1;
	localparam logic [2:0] STAT_SIZE    = 3'd2;
	localparam logic [2:0] STAT_PALETTE = 3'd3;
	localparam logic [2:0] STAT_CHUNK   = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
	localparam logic [1:0] CFG_RATE_NUM    = 2'd1;
	localparam logic [1:0] CFG_RATE_DEN    = 2'd2;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] in_byte;
	} req_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         data_byte;
		logic               last;
		logic [2:0]         status;
		logic [15:0]        width;
		logic [15:0]        height;
		logic [1:0]         channels;
		logic [VIDEO_W-1:0] video_bytes;
		logic [15:0]        audio_bytes;
		logic [15:0]        rate_num;
		logic [15:0]        rate_den;
		logic [15:0]        audio_rate;
	} res_t;

	typedef enum logic [3:0] {
		ST_HDR,
		ST_MUL1,
		ST_MUL2,
		ST_CHECK,
		ST_DESC,
		ST_HEAD,
		ST_VIDEO,
		ST_AUDIO,
		ST_PAD,
		ST_HALT
	} state_t;

	typedef struct packed {
		logic       hdr_shift;
		logic       hdr_rotate;
		logic       calc1;
		logic       calc2;
		logic       calc3;
		logic       load_video;
		logic       load_audio;
		logic       dec_left;
		logic       dec_pad;
		logic       emit;
		logic       from_hdr;
		logic [2:0] kind;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
		logic hdr_full;
		logic head_last;
		logic err;
		logic video_zero;
		logic audio_zero;
		logic pad_zero;
		logic pad_one;
		logic left_one;
	} sts_t;

endpackage

// File: rtl/pvcd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvcd_datapath
// Header shift line, decode arithmetic, byte counters, config and result register.
// ----------------------------------------------------------------------------
module pvcd_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  pvcd_pkg::req_t req,
	input  logic           res_stall,
	output logic           res_valid,
	output pvcd_pkg::res_t res,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	input  pvcd_pkg::cmd_t cmd,
	output pvcd_pkg::sts_t sts
);
	import pvcd_pkg::*;

	logic [7:0]           hdr_q [HDR_BYTES];
	logic [HDR_IDX_W-1:0] hcnt_q;
	logic [HDR_IDX_W-1:0] hidx_q;
	logic [15:0]          cfg_srate_q, cfg_rnum_q, cfg_rden_q;

	logic [31:0] chunk;
	logic [15:0] w, h, pal, asz, srate_h;
	logic [7:0]  planes, rb;
	logic        chan2;
	logic [16:0] aligned;
	logic [15:0] audio;
	logic [15:0] srate_eff;

	logic [32:0] pa_s1;
	logic [31:0] pw_s1;
	logic [40:0] pa_s2;
	logic [39:0] pw_s2;

	logic [40:0] image;
	logic [40:0] video;
	logic [41:0] total;
	logic [2:0]  code;

	logic [2:0]         err_q;
	logic [VIDEO_W-1:0] video_q;
	logic [31:0]        pad_q;
	logic [15:0]        audio_q, srate_q, rnum_q, rden_q;
	logic [LEFT_W-1:0]  left_q;

	logic res_valid_q;
	res_t res_q, res_d;

	// Header field extraction, big-endian
	always_comb begin
		chunk   = {hdr_q[2], hdr_q[3], hdr_q[4], hdr_q[5]};
		w       = {hdr_q[14], hdr_q[15]};
		h       = {hdr_q[16], hdr_q[17]};
		planes  = hdr_q[19];
		pal     = {hdr_q[20], hdr_q[21]};
		asz     = {hdr_q[22], hdr_q[23]};
		srate_h = {hdr_q[24], hdr_q[25]};
		rb      = hdr_q[26];
		chan2   = hdr_q[1][4];
		aligned = ({1'b0, w} + 17'd15) & ~17'hf;
		audio   = chan2 ? {asz[14:0], 1'b0} : asz;
		srate_eff = (srate_h == 16'd0 && audio != 16'd0) ? cfg_srate_q : srate_h;
	end

	// Header shift line: shift in stream bytes, rotate while replaying
	always_ff @(posedge clk) begin
		if (cmd.hdr_shift || cmd.hdr_rotate) begin
			for (int i = 0; i < HDR_BYTES - 1; i++) begin
				hdr_q[i] <= hdr_q[i+1];
			end
			hdr_q[HDR_BYTES-1] <= cmd.hdr_shift ? req.in_byte : hdr_q[0];
		end
	end

	// Header byte counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= '0;
			hidx_q <= '0;
		end else begin
			if (cmd.hdr_shift)  hcnt_q <= hcnt_q + 1'b1;
			if (cmd.hdr_rotate) hidx_q <= hidx_q + 1'b1;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_srate_q <= RST_SAMPLE_RATE;
			cfg_rnum_q  <= RST_RATE_NUM;
			cfg_rden_q  <= RST_RATE_DEN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SAMPLE_RATE: cfg_srate_q <= cfg_data;
				CFG_RATE_NUM:    cfg_rnum_q  <= cfg_data;
				CFG_RATE_DEN:    cfg_rden_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Size products over two stages
	always_ff @(posedge clk) begin
		if (cmd.calc1) begin
			pa_s1 <= 33'(aligned) * 33'(h);
			pw_s1 <= 32'(w) * 32'(h);
		end
		if (cmd.calc2) begin
			pa_s2 <= 41'(pa_s1) * 41'(planes);
			pw_s2 <= 40'(pw_s1) * 40'(planes);
		end
	end

	// Checks and sizes
	always_comb begin
		image = ((hdr_q[1] & 8'he0) == 8'h20) ? {4'd0, pw_s2[39:3]} : {3'd0, pa_s2[40:3]};
		video = 41'(pal) + image;
		total = 42'(audio) + 42'(video) + 42'(HDR_BYTES);
		if (hdr_q[0] > 8'd1)
			code = STAT_TYPE;
		else if (planes == 8'd0 || pa_s2 > 41'h7fff_ffff)
			code = STAT_SIZE;
		else if ((hdr_q[0] == 8'd1 && pal > 16'd512) || (hdr_q[0] == 8'd0 && pal > 16'd768))
			code = STAT_PALETTE;
		else if (42'(chunk) < total)
			code = STAT_CHUNK;
		else
			code = STAT_OK;
	end

	// Latch decode results and derive the rates
	always_ff @(posedge clk) begin
		if (cmd.calc3) begin
			err_q   <= code;
			video_q <= video[VIDEO_W-1:0];
			pad_q   <= chunk - total[31:0];
			audio_q <= audio;
			srate_q <= srate_eff;
			if (rb == 8'd0 && audio != 16'd0 && srate_eff != 16'd0) begin
				rnum_q <= srate_eff;
				rden_q <= audio;
			end else if (rb == 8'd0) begin
				rnum_q <= cfg_rnum_q;
				rden_q <= cfg_rden_q;
			end else begin
				rnum_q <= {8'd0, rb};
				rden_q <= 16'd1;
			end
		end else if (cmd.dec_pad) begin
			pad_q <= pad_q - 32'd1;
		end
	end

	// Packet byte counter
	always_ff @(posedge clk) begin
		if (cmd.load_video)
			left_q <= video_q;
		else if (cmd.load_audio)
			left_q <= LEFT_W'(audio_q);
		else if (cmd.dec_left)
			left_q <= left_q - 1'b1;
	end

	// Build the next result
	always_comb begin
		res_d      = '0;
		res_d.kind = cmd.kind;
		case (cmd.kind)
			KIND_DESC: begin
				res_d.width       = w;
				res_d.height      = h;
				res_d.channels    = chan2 ? 2'd2 : 2'd1;
				res_d.video_bytes = video_q;
				res_d.audio_bytes = audio_q;
				res_d.rate_num    = rnum_q;
				res_d.rate_den    = rden_q;
				res_d.audio_rate  = srate_q;
			end
			KIND_VIDEO, KIND_AUDIO: begin
				res_d.data_byte = cmd.from_hdr ? hdr_q[0] : req.in_byte;
				res_d.last      = cmd.from_hdr ? (sts.head_last && sts.video_zero)
				                               : sts.left_one;
			end
			KIND_ERR: res_d.status = err_q;
			default: ;
		endcase
	end

	// Result register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.emit)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Status to the controller
	always_comb begin
		sts.out_busy   = res_valid_q && res_stall;
		sts.hdr_full   = (hcnt_q == HDR_IDX_W'(HDR_BYTES - 1));
		sts.head_last  = (hidx_q == HDR_IDX_W'(HDR_BYTES - 1));
		sts.err        = (err_q != STAT_OK);
		sts.video_zero = (video_q == '0);
		sts.audio_zero = (audio_q == 16'd0);
		sts.pad_zero   = (pad_q == 32'd0);
		sts.pad_one    = (pad_q == 32'd1);
		sts.left_one   = (left_q == LEFT_W'(1));
	end

endmodule

// File: rtl/pvcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvcd_ctrl
// Phase sequencer: header capture, decode, replay, payload, padding, halt.
// ----------------------------------------------------------------------------
module pvcd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_op,
	output logic           req_stall,
	input  pvcd_pkg::sts_t sts,
	output pvcd_pkg::cmd_t cmd
);
	import pvcd_pkg::*;

	state_t state_q, state_n;
	logic   acc;

	assign acc = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_HDR;
		else         state_q <= state_n;
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_HDR: begin
				if (acc && req_op == OP_END) state_n = ST_HALT;
				else if (acc && sts.hdr_full) state_n = ST_MUL1;
			end
			ST_MUL1:  state_n = ST_MUL2;
			ST_MUL2:  state_n = ST_CHECK;
			ST_CHECK: state_n = ST_DESC;
			ST_DESC: begin
				if (!sts.out_busy) state_n = sts.err ? ST_HALT : ST_HEAD;
			end
			ST_HEAD: begin
				if (!sts.out_busy && sts.head_last) begin
					if (!sts.video_zero)      state_n = ST_VIDEO;
					else if (!sts.audio_zero) state_n = ST_AUDIO;
					else if (sts.pad_zero)    state_n = ST_HDR;
					else                      state_n = ST_PAD;
				end
			end
			ST_VIDEO: begin
				if (acc && req_op == OP_END) state_n = ST_HALT;
				else if (acc && sts.left_one) begin
					if (!sts.audio_zero)   state_n = ST_AUDIO;
					else if (sts.pad_zero) state_n = ST_HDR;
					else                   state_n = ST_PAD;
				end
			end
			ST_AUDIO: begin
				if (acc && req_op == OP_END) state_n = ST_HALT;
				else if (acc && sts.left_one) state_n = sts.pad_zero ? ST_HDR : ST_PAD;
			end
			ST_PAD: begin
				if (acc && req_op == OP_END) state_n = ST_HALT;
				else if (acc && sts.pad_one) state_n = ST_HDR;
			end
			ST_HALT: state_n = ST_HALT;
			default: state_n = ST_HALT;
		endcase
	end

	// Commands and input stall
	always_comb begin
		cmd       = '0;
		cmd.kind  = KIND_END;
		req_stall = 1'b1;
		case (state_q)
			ST_HDR, ST_VIDEO, ST_AUDIO, ST_PAD: begin
				req_stall = sts.out_busy;
				if (acc && req_op == OP_END) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_END;
				end else if (acc) begin
					case (state_q)
						ST_HDR: cmd.hdr_shift = 1'b1;
						ST_VIDEO: begin
							cmd.emit       = 1'b1;
							cmd.kind       = KIND_VIDEO;
							cmd.dec_left   = 1'b1;
							cmd.load_audio = sts.left_one && !sts.audio_zero;
						end
						ST_AUDIO: begin
							cmd.emit     = 1'b1;
							cmd.kind     = KIND_AUDIO;
							cmd.dec_left = 1'b1;
						end
						default: cmd.dec_pad = 1'b1;
					endcase
				end
			end
			ST_MUL1:  cmd.calc1 = 1'b1;
			ST_MUL2:  cmd.calc2 = 1'b1;
			ST_CHECK: cmd.calc3 = 1'b1;
			ST_DESC: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.kind = sts.err ? KIND_ERR : KIND_DESC;
				end
			end
			ST_HEAD: begin
				if (!sts.out_busy) begin
					cmd.emit       = 1'b1;
					cmd.kind       = KIND_VIDEO;
					cmd.from_hdr   = 1'b1;
					cmd.hdr_rotate = 1'b1;
					if (sts.head_last) begin
						cmd.load_video = !sts.video_zero;
						cmd.load_audio = sts.video_zero && !sts.audio_zero;
					end
				end
			end
			ST_HALT: req_stall = 1'b0;
			default: req_stall = 1'b0;
		endcase
	end

endmodule

// File: rtl/palette_video_chunk_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_video_chunk_deframer
// Splits a chunked palette video byte stream into descriptor, video and audio.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one stream byte (op = data) or end of stream per request.
//   res channel: descriptor, video byte, audio byte, error or end results.
//   cfg port: fallback sample rate and frame rate, written while idle.
// Timing:
//   Header bytes are taken one per cycle while no result is held. After
//   the 32nd byte the decode runs through two multiply stages and a check
//   stage, then the descriptor and, if no error, the 32 replayed header
//   bytes leave one per cycle while no result is held. Payload and padding
//   bytes are taken likewise; payload bytes leave via the result register.
// Reset: all control clears, fallbacks return to 11025 Hz and 15/1 fps,
//   the block waits for a header.
// Stall: requests are held off during decode and replay, and while a result
//   is held they are stalled, except after halt; an error or end halts the
//   block until reset, inputs then dropped.
// ----------------------------------------------------------------------------
module palette_video_chunk_deframer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pvcd_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output pvcd_pkg::res_t res,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data
);
	import pvcd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Phase sequencer
	pvcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.op),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Header store, arithmetic and result register
	pvcd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: rtl/pvcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvcd_checker
// Port-level checks on the result channel of the chunk deframer.
// ----------------------------------------------------------------------------
`include "palette_video_chunk_deframer_macros.svh"

module pvcd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_stall,
	input pvcd_pkg::res_t res
);
	import pvcd_pkg::*;

	// Hold a stalled result
	`PVCD_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

	// Descriptor carries no status and a legal channel count
	`PVCD_ASSERT_NOW(a_desc_fields, res_valid && res.kind == KIND_DESC,
		res.status == STAT_OK && (res.channels == 2'd1 || res.channels == 2'd2))

	// End result carries nothing else
	`PVCD_ASSERT_NOW(a_end_clean, res_valid && res.kind == KIND_END,
		res.data_byte == 8'd0 && res.last == 1'b0 && res.status == STAT_OK)

	// Error result has a nonzero code
	`PVCD_ASSERT_NOW(a_err_code, res_valid && res.kind == KIND_ERR,
		res.status != STAT_OK && res.last == 1'b0)

endmodule

bind palette_video_chunk_deframer pvcd_checker u_pvcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
